/* src/lsom_pkg.sv */
// Shared constants, types and tables for the laser scan offset merge block.
`timescale 1ns / 1ps
`default_nettype none
package lsom_pkg;

	localparam int MAX_SLOTS     = 4096;
	localparam int RANGE_BITS    = 16;
	localparam int CORDIC_STAGES = 20;
	localparam int ABS_W         = 22;   // |slot + shift| stays below 2^21

	localparam logic [16:0] DEG90  = 17'd23040;
	localparam logic [16:0] DEG180 = 17'd46080;
	localparam logic [16:0] DEG270 = 17'd69120;
	localparam logic [16:0] DEG360 = 17'd92160;
	localparam logic [29:0] KINV_Q30   = 30'd652032874;
	localparam logic [23:0] KINV_Q24   = 24'd10188014;
	localparam logic [30:0] ONE_Q30    = 31'd1073741824;
	localparam logic [16:0] MERGED_MAX = 17'd131071;
	// ceil(2^26 / 45): hw/23040 = (hw >> 9) / 45
	localparam logic [20:0] RECIP45    = 21'd1491309;

	typedef enum logic [2:0] {
		REG_FRONT_OFFSET_X = 3'd0,
		REG_FRONT_OFFSET_Y = 3'd1,
		REG_BACK_OFFSET_X  = 3'd2,
		REG_BACK_OFFSET_Y  = 3'd3,
		REG_ANGLE_STEP     = 3'd4,
		REG_SAMPLE_COUNT   = 3'd5
	} reg_idx_t;

	// atan(2^-i) in 1/65536 degree
	localparam logic [22:0] ATAN_TAB [0:31] = '{
		23'd2949120, 23'd1740967, 23'd919879, 23'd466945, 23'd234379, 23'd117304,
		23'd58666, 23'd29335, 23'd14668, 23'd7334, 23'd3667, 23'd1833, 23'd917,
		23'd458, 23'd229, 23'd115, 23'd57, 23'd29, 23'd14, 23'd7, 23'd4, 23'd2,
		23'd1, 23'd0, 23'd0, 23'd0, 23'd0, 23'd0, 23'd0, 23'd0, 23'd0, 23'd0
	};

	// per-slot sideband that rides along the geometry pipeline
	typedef struct packed {
		logic                  nr;
		logic                  zero;
		logic [11:0]           slot;
		logic [RANGE_BITS-1:0] rng;
		logic [11:0]           ox;
		logic [11:0]           oy;
		logic [28:0]           hw;
	} side_t;

	// sideband through the remainder pipeline
	typedef struct packed {
		logic        nr;
		logic        neg;
		logic [11:0] slot;
		logic [16:0] merged;
	} mside_t;

endpackage
`default_nettype wire

/* src/laser_scan_offset_merge.sv */
// Top level: front/back laser slot merge with offset correction, fully pipelined.
//
// Usage
//   Input: present a slot on slot_index, front_range/front_hit, back_range/back_hit
//   and raise start; the beat is taken at an edge where start is high and busy is
//   low. busy is never raised, so one slot may be taken on every clock.
//   Output: each accepted slot yields one result beat,
//   marked by done for one cycle, carrying target_slot, merged_range, no_return.
//   Results leave in input order. The receiver cannot stall the block; every
//   stage advances each cycle and valid bits travel with the data.
//   Latency is set by the two 20-stage CORDIC pipelines (rotation for sin/cos,
//   vectoring for atan and hypotenuse) and the 22-stage remainder pipeline
//   that wraps the target slot modulo sample_count; throughput is one slot/cycle.
//   Configuration: cfg_valid/cfg_ready/cfg_index/cfg_data write one register per
//   beat (cfg_ready is always high); unknown indices are ignored. Write only
//   while no slot is in flight.
//   Reset (arst_n low) empties the pipeline and restores offsets to 0,
//   angle_step to 256 (one degree) and sample_count to 360.
`timescale 1ns / 1ps
`default_nettype none
module laser_scan_offset_merge import lsom_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [11:0]           slot_index,
	input  wire logic [15:0]           front_range,
	input  wire logic                  front_hit,
	input  wire logic [15:0]           back_range,
	input  wire logic                  back_hit,
	output logic                       done,
	output logic [11:0]                target_slot,
	output logic [16:0]                merged_range,
	output logic                       no_return,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [2:0]            cfg_index,
	input  wire logic [16:0]           cfg_data
);

	localparam int LAT = 70;

	// ---------------- configuration registers ----------------
	logic [11:0] front_ox_q, front_oy_q, back_ox_q, back_oy_q;
	logic [16:0] angle_step_q;
	logic [12:0] sample_count_q;
	logic [12:0] modulus;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_ox_q     <= '0;
			front_oy_q     <= '0;
			back_ox_q      <= '0;
			back_oy_q      <= '0;
			angle_step_q   <= 17'd256;
			sample_count_q <= 13'd360;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_FRONT_OFFSET_X: front_ox_q     <= cfg_data[11:0];
				REG_FRONT_OFFSET_Y: front_oy_q     <= cfg_data[11:0];
				REG_BACK_OFFSET_X:  back_ox_q      <= cfg_data[11:0];
				REG_BACK_OFFSET_Y:  back_oy_q      <= cfg_data[11:0];
				REG_ANGLE_STEP:     angle_step_q   <= cfg_data;
				REG_SAMPLE_COUNT:   sample_count_q <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	// zero or oversize count falls back to the full slot range
	assign modulus = (sample_count_q == '0 || sample_count_q > 13'(MAX_SLOTS))
		? 13'(MAX_SLOTS) : sample_count_q;

	// ---------------- s1: reading select, slot angle ----------------
	logic        v_s1;
	side_t       sb_s1;
	logic [29:0] hw_raw;

	assign hw_raw = 30'(slot_index) * 30'(angle_step_q) + 30'(DEG90);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		sb_s1.slot <= slot_index;
		sb_s1.zero <= 1'b0;
		sb_s1.hw   <= (hw_raw > 30'(DEG360)) ? 29'(hw_raw - 30'(DEG360)) : hw_raw[28:0];
		if (front_hit) begin
			sb_s1.nr  <= 1'b0;
			sb_s1.rng <= front_range[RANGE_BITS-1:0];
			sb_s1.ox  <= front_ox_q;
			sb_s1.oy  <= front_oy_q;
		end else begin
			sb_s1.nr  <= !back_hit;
			sb_s1.rng <= back_range[RANGE_BITS-1:0];
			sb_s1.ox  <= back_ox_q;
			sb_s1.oy  <= back_oy_q;
		end
	end

	// ---------------- s2: quadrant number hw / 90deg ----------------
	logic        v_s2;
	side_t       sb_s2;
	logic [14:0] quad_s2;
	logic [40:0] recip_prod;

	assign recip_prod = 41'(sb_s1.hw[28:9]) * 41'(RECIP45);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		sb_s2   <= sb_s1;
		quad_s2 <= recip_prod[40:26];
	end

	// ---------------- s3: fold into first quadrant, seed rotation ----------------
	logic [28:0] rem_full;
	logic [14:0] rem90;
	logic [14:0] phi;

	always_comb begin
		rem_full = sb_s2.hw - 29'(quad_s2) * 29'(DEG90);
		rem90    = rem_full[14:0];
		phi      = quad_s2[0] ? 15'(DEG90 - 17'(rem90)) : rem90;
	end

	logic               rot_v_s [0:CORDIC_STAGES];
	side_t              rot_sb_s [0:CORDIC_STAGES];
	logic signed [32:0] rot_x_s [0:CORDIC_STAGES];
	logic signed [32:0] rot_y_s [0:CORDIC_STAGES];
	logic signed [24:0] rot_z_s [0:CORDIC_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_v_s[0] <= 1'b0;
		end else begin
			rot_v_s[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		rot_sb_s[0] <= sb_s2;
		rot_x_s[0]  <= 33'(KINV_Q30);
		rot_y_s[0]  <= '0;
		rot_z_s[0]  <= 25'({phi, 8'd0});
	end

	// rotation CORDIC: sin/cos of phi
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
		logic signed [32:0] dx, dy;
		logic signed [24:0] at;
		assign dx = rot_y_s[i] >>> i;
		assign dy = rot_x_s[i] >>> i;
		assign at = 25'(ATAN_TAB[i]);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rot_v_s[i+1] <= 1'b0;
			end else begin
				rot_v_s[i+1] <= rot_v_s[i];
			end
		end
		always_ff @(posedge clk) begin
			rot_sb_s[i+1] <= rot_sb_s[i];
			if (rot_z_s[i] >= 0) begin
				rot_x_s[i+1] <= rot_x_s[i] - dx;
				rot_y_s[i+1] <= rot_y_s[i] + dy;
				rot_z_s[i+1] <= rot_z_s[i] - at;
			end else begin
				rot_x_s[i+1] <= rot_x_s[i] + dx;
				rot_y_s[i+1] <= rot_y_s[i] - dy;
				rot_z_s[i+1] <= rot_z_s[i] + at;
			end
		end
	end

	// ---------------- clamp sin/cos to [0, 1] ----------------
	logic        v_c;
	side_t       sb_c;
	logic [30:0] sin_c, cos_c;

	function automatic logic [30:0] clamp_q30(input logic signed [32:0] v);
		if (v < 0)
			return '0;
		else if (v > $signed({2'b00, ONE_Q30}))
			return ONE_Q30;
		else
			return v[30:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_c <= 1'b0;
		end else begin
			v_c <= rot_v_s[CORDIC_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		sb_c  <= rot_sb_s[CORDIC_STAGES];
		sin_c <= clamp_q30(rot_y_s[CORDIC_STAGES]);
		cos_c <= clamp_q30(rot_x_s[CORDIC_STAGES]);
	end

	// ---------------- components plus offsets, seed vectoring ----------------
	logic [46:0] prod_y, prod_x;
	logic [25:0] comp_y, comp_x;
	side_t       sb_cz;

	always_comb begin
		prod_y = 47'(sb_c.rng) * 47'(sin_c) + 47'(1 << 21);
		prod_x = 47'(sb_c.rng) * 47'(cos_c) + 47'(1 << 21);
		comp_y = 26'(prod_y[46:22]) + 26'({sb_c.ox, 8'd0});
		comp_x = 26'(prod_x[46:22]) + 26'({sb_c.oy, 8'd0});
		sb_cz      = sb_c;
		sb_cz.zero = (comp_x == '0) && (comp_y == '0);
	end

	logic               vec_v_s [0:CORDIC_STAGES];
	side_t              vec_sb_s [0:CORDIC_STAGES];
	logic signed [28:0] vec_x_s [0:CORDIC_STAGES];
	logic signed [28:0] vec_y_s [0:CORDIC_STAGES];
	logic signed [24:0] vec_z_s [0:CORDIC_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vec_v_s[0] <= 1'b0;
		end else begin
			vec_v_s[0] <= v_c;
		end
	end

	always_ff @(posedge clk) begin
		vec_sb_s[0] <= sb_cz;
		vec_x_s[0]  <= 29'(comp_x);
		vec_y_s[0]  <= 29'(comp_y);
		vec_z_s[0]  <= '0;
	end

	// vectoring CORDIC: angle and magnitude of (bx, by)
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
		logic signed [28:0] dx, dy;
		logic signed [24:0] at;
		assign dx = vec_y_s[i] >>> i;
		assign dy = vec_x_s[i] >>> i;
		assign at = 25'(ATAN_TAB[i]);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vec_v_s[i+1] <= 1'b0;
			end else begin
				vec_v_s[i+1] <= vec_v_s[i];
			end
		end
		always_ff @(posedge clk) begin
			vec_sb_s[i+1] <= vec_sb_s[i];
			if (vec_y_s[i] >= 0) begin
				vec_x_s[i+1] <= vec_x_s[i] + dx;
				vec_y_s[i+1] <= vec_y_s[i] - dy;
				vec_z_s[i+1] <= vec_z_s[i] + at;
			end else begin
				vec_x_s[i+1] <= vec_x_s[i] - dx;
				vec_y_s[i+1] <= vec_y_s[i] + dy;
				vec_z_s[i+1] <= vec_z_s[i] - at;
			end
		end
	end

	// ---------------- gain correction, angle rounding ----------------
	logic               v_g;
	side_t              sb_g;
	logic [16:0]        merged_g;
	logic [14:0]        beta_g;
	logic [27:0]        mag;
	logic [51:0]        mag_prod;
	logic [22:0]        z_clamped;
	logic [23:0]        z_round;
	logic signed [28:0] vx_end;
	logic signed [24:0] vz_end;

	always_comb begin
		vx_end    = vec_x_s[CORDIC_STAGES];
		vz_end    = vec_z_s[CORDIC_STAGES];
		mag       = (vx_end < 0) ? '0 : vx_end[27:0];
		mag_prod  = 52'(mag) * 52'(KINV_Q24) + 52'(64'd1 << 31);
		if (vz_end < 0)
			z_clamped = '0;
		else if (vz_end > 25'(DEG90 * 256))
			z_clamped = 23'(DEG90 * 256);
		else
			z_clamped = vz_end[22:0];
		z_round = 24'(z_clamped) + 24'd128;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_g <= 1'b0;
		end else begin
			v_g <= vec_v_s[CORDIC_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		sb_g <= vec_sb_s[CORDIC_STAGES];
		if (vec_sb_s[CORDIC_STAGES].zero) begin
			beta_g   <= '0;
			merged_g <= '0;
		end else begin
			beta_g   <= z_round[22:8];
			merged_g <= (mag_prod[51:32] > 20'(MERGED_MAX)) ? MERGED_MAX : mag_prod[48:32];
		end
	end

	// ---------------- quadrant restore, rounded slot shift ----------------
	logic signed [30:0] beta2, diff, diff_abs;
	logic signed [22:0] shift_rd;
	logic signed [23:0] new_slot;
	logic [28:0]        hw_g;

	always_comb begin
		hw_g = sb_g.hw;
		priority if (hw_g >= 29'(DEG90) && hw_g < 29'(DEG180))
			beta2 = 31'(DEG180) - 31'(beta_g);
		else if (hw_g >= 29'(DEG180) && hw_g < 29'(DEG270))
			beta2 = 31'(beta_g) + 31'(DEG180);
		else if (hw_g >= 29'(DEG270))
			beta2 = 31'(DEG360) - 31'(beta_g);
		else
			beta2 = 31'(beta_g);
		diff     = beta2 - $signed({2'b00, hw_g});
		diff_abs = (diff < 0) ? -diff : diff;
		// half away from zero
		shift_rd = (diff < 0) ? -23'((diff_abs + 31'sd128) >>> 8)
			: 23'((diff_abs + 31'sd128) >>> 8);
		new_slot = 24'($signed({1'b0, sb_g.slot})) + 24'(shift_rd);
	end

	logic             v_n;
	logic [ABS_W-1:0] abs_n;
	mside_t           msb_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_n <= 1'b0;
		end else begin
			v_n <= v_g;
		end
	end

	always_ff @(posedge clk) begin
		abs_n        <= (new_slot < 0) ? ABS_W'(-new_slot) : ABS_W'(new_slot);
		msb_n.neg    <= new_slot < 0;
		msb_n.nr     <= sb_g.nr;
		msb_n.slot   <= sb_g.slot;
		msb_n.merged <= merged_g;
	end

	// ---------------- wrap modulo sample count ----------------
	logic        v_m;
	logic [12:0] rem_m;
	mside_t      msb_m;

	lsom_mod_pipe u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_v     (v_n),
		.in_abs   (abs_n),
		.in_side  (msb_n),
		.modulus  (modulus),
		.out_v    (v_m),
		.out_rem  (rem_m),
		.out_side (msb_m)
	);

	// negative value: remainder folds back from the top of the range
	logic [12:0] wrapped;
	assign wrapped = (msb_m.neg && rem_m != '0) ? (modulus - rem_m) : rem_m;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_m;
		end
	end

	always_ff @(posedge clk) begin
		if (msb_m.nr) begin
			target_slot  <= msb_m.slot;
			merged_range <= '0;
			no_return    <= 1'b1;
		end else begin
			target_slot  <= wrapped[11:0];
			merged_range <= msb_m.merged;
			no_return    <= 1'b0;
		end
	end

	// ---------------- checks ----------------
	a_nr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && no_return |-> merged_range == '0)
		else $error("no-return beat with non-zero range");

	a_slot_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && !no_return |-> {1'b0, target_slot} < modulus)
		else $error("target slot outside sample count");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("result beat missing at expected latency");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		v_m |-> $past(v_n, ABS_W))
		else $error("remainder pipeline produced an unrequested beat");

endmodule
`default_nettype wire

/* src/lsom_mod_pipe.sv */
// Pipelined restoring remainder: one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module lsom_mod_pipe import lsom_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_v,
	input  wire logic [ABS_W-1:0] in_abs,
	input  wire mside_t           in_side,
	input  wire logic [12:0]      modulus,
	output logic                  out_v,
	output logic [12:0]           out_rem,
	output mside_t                out_side
);

	logic             v_s   [0:ABS_W];
	logic [ABS_W-1:0] num_s [0:ABS_W];
	logic [12:0]      rem_s [0:ABS_W];
	mside_t           sb_s  [0:ABS_W];

	assign v_s[0]   = in_v;
	assign num_s[0] = in_abs;
	assign rem_s[0] = '0;
	assign sb_s[0]  = in_side;

	for (genvar j = 0; j < ABS_W; j++) begin : g_stage
		logic [13:0] trial;
		logic [13:0] sub;
		always_comb begin
			trial = {rem_s[j], num_s[j][ABS_W-1]};
			sub   = trial - {1'b0, modulus};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else begin
				v_s[j+1] <= v_s[j];
			end
		end
		always_ff @(posedge clk) begin
			num_s[j+1] <= {num_s[j][ABS_W-2:0], 1'b0};
			rem_s[j+1] <= (trial >= {1'b0, modulus}) ? sub[12:0] : trial[12:0];
			sb_s[j+1]  <= sb_s[j];
		end
	end

	assign out_v    = v_s[ABS_W];
	assign out_rem  = rem_s[ABS_W];
	assign out_side = sb_s[ABS_W];

endmodule
`default_nettype wire
